@@ rtl/tcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and pattern constants for the text content classifier.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned WinDepth = 9;
  localparam int unsigned LenW     = 4;
  localparam int unsigned FlagW    = 7;

  localparam logic [LenW-1:0] LEN_MAX = 4'd8;

  typedef logic [WinDepth-1:0][7:0] window_t;
  typedef logic [FlagW-1:0]         flags_t;
  typedef logic [LenW-1:0]          len_t;

  // flag bit positions
  localparam int unsigned FLAG_DATE   = 0;
  localparam int unsigned FLAG_TIME   = 1;
  localparam int unsigned FLAG_TEXT   = 2;
  localparam int unsigned FLAG_COORD  = 3;
  localparam int unsigned FLAG_TEMP   = 4;
  localparam int unsigned FLAG_NUMBER = 5;
  localparam int unsigned FLAG_ISBN   = 6;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_G     = 8'h47;

  // masks and patterns
  localparam logic [31:0] M_DATE4    = 32'hF0F0F0F0;
  localparam logic [31:0] P_DATE4    = 32'h30303030;
  localparam logic [31:0] M_DATE_A   = 32'hFDF0F0FD;
  localparam logic [31:0] P_DATE_A   = 32'h2D30302D;
  localparam logic [31:0] M_DATE_B   = 32'hF0FDF0FD;
  localparam logic [31:0] P_DATE_B   = 32'h302D302D;
  localparam logic [31:0] M_DATE_C   = 32'hF0F0FDF0;
  localparam logic [31:0] P_DATE_C   = 32'h30302D30;
  localparam logic [31:0] M_DATE_D   = 32'hF0F0F0FD;
  localparam logic [31:0] P_DATE_D   = 32'h3030302D;
  localparam logic [31:0] M_DATE_E   = 32'hF0FDF0F0;
  localparam logic [31:0] P_DATE_E   = 32'h302D3030;
  localparam logic [31:0] M_TIME4    = 32'hF0FFF0F0;
  localparam logic [31:0] P_TIME4    = 32'h303A3030;
  localparam logic [31:0] M_TIME8    = 32'hF0F0FF00;
  localparam logic [31:0] P_TIME8    = 32'h30303A00;
  localparam logic [31:0] M_ASCII    = 32'h80808080;
  localparam logic [31:0] M_COORD8   = 32'h00F0F0FF;
  localparam logic [31:0] P_COORD8   = 32'h003030C2;
  localparam logic [31:0] M_COORD4   = 32'hFFF0F0FF;
  localparam logic [31:0] P_COORD4   = 32'hB0303027;
  localparam logic [31:0] M_TEMP4    = 32'h00FFFFFA;
  localparam logic [31:0] P_TEMP4    = 32'h00C2B042;
  localparam logic [31:0] P_ISBN     = 32'h4953424E;

  function automatic logic is_digit(input logic [7:0] v);
    return (v >= 8'h30) && (v <= 8'h39);
  endfunction

endpackage

@@ rtl/tcc_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_match
// Masked pattern tests over the nine-byte window, one flag per content kind.
// ----------------------------------------------------------------------------
module tcc_match (
  input  tcc_pkg::window_t win,
  input  tcc_pkg::len_t    len,
  output tcc_pkg::flags_t  hits
);

  logic [31:0] c4;
  logic [31:0] c8;
  logic [8:0]  dig;
  logic        date_hit;

  assign c4 = {win[3], win[2], win[1], win[0]};
  assign c8 = {win[7], win[6], win[5], win[4]};

  // dig[i] is the digit test of byte i+1, newest first
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      dig[i] = tcc_pkg::is_digit(win[i]);
    end
  end

  always_comb begin
    if ((c4 & tcc_pkg::M_DATE4) == tcc_pkg::P_DATE4) begin
      date_hit = dig[0] && dig[1] && dig[2] && dig[3] &&
                 ((((c8 & tcc_pkg::M_DATE_A) == tcc_pkg::P_DATE_A) && dig[8]) ||
                  ((c8 & tcc_pkg::M_DATE_B) == tcc_pkg::P_DATE_B));
    end else begin
      date_hit = (((c8 & tcc_pkg::M_DATE_C) == tcc_pkg::P_DATE_C) ||
                  ((c8 & tcc_pkg::M_DATE_D) == tcc_pkg::P_DATE_D)) &&
                 dig[8] && dig[6] && dig[7] &&
                 ((c4 & tcc_pkg::M_DATE_E) == tcc_pkg::P_DATE_E);
    end
  end

  always_comb begin
    hits = '0;
    hits[tcc_pkg::FLAG_DATE] = date_hit;
    hits[tcc_pkg::FLAG_TIME] = ((c4 & tcc_pkg::M_TIME4) == tcc_pkg::P_TIME4) && dig[4] &&
                               (!dig[5] ||
                                (((c8 & tcc_pkg::M_TIME8) == tcc_pkg::P_TIME8) && !dig[8]));
    hits[tcc_pkg::FLAG_TEXT] = (len >= tcc_pkg::LEN_MAX) &&
                               (((c8 | c4) & tcc_pkg::M_ASCII) == 32'h0);
    hits[tcc_pkg::FLAG_COORD] = ((c8 & tcc_pkg::M_COORD8) == tcc_pkg::P_COORD8) &&
                                ((c4 & tcc_pkg::M_COORD4) == tcc_pkg::P_COORD4) &&
                                dig[1] && dig[2] && dig[5] && dig[6];
    hits[tcc_pkg::FLAG_TEMP] = ((c4 & tcc_pkg::M_TEMP4) == tcc_pkg::P_TEMP4) &&
                               (win[0] != tcc_pkg::CHR_G) &&
                               (dig[3] || ((win[3] == tcc_pkg::CHR_SPACE) && dig[4]));
    hits[tcc_pkg::FLAG_NUMBER] = dig[0];
    hits[tcc_pkg::FLAG_ISBN] = (c4 == tcc_pkg::P_ISBN) && (win[4] == tcc_pkg::CHR_SPACE);
  end

endmodule

@@ rtl/text_content_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_content_classifier_top
// Byte stream content classifier: sticky flags from a nine-byte window.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tuser
//  in_     | in  | [7:0] byte_in          | [0] start_content, [1] count_byte
//  out_    | out | [6:0] content_flags    | -
//
//  one byte per cycle sustained while the output is not stalled; a request
//  is held in the input register, is classified and lands in the result
//  register, from which its result leaves.
//  reset clears both valid flags, the window, the flags and the length.
//  a stalled result holds; the input register still takes one more byte.
// ----------------------------------------------------------------------------
module text_content_classifier_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  input  logic [1:0] in_tuser,   // [0] start_content, [1] count_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [6:0] content_flags, [7] zero
);

  logic              s1_v_r, s1_v_nxt;
  logic [7:0]        s1_byte_r;
  logic              s1_start_r;
  logic              s1_count_r;
  logic              out_v_r, out_v_nxt;
  logic [7:0]        out_data_r;
  tcc_pkg::window_t  hist_r;
  tcc_pkg::flags_t   flags_r;
  tcc_pkg::len_t     len_r;

  tcc_pkg::window_t  win;
  tcc_pkg::len_t     len_nxt;
  tcc_pkg::flags_t   flags_nxt;
  tcc_pkg::flags_t   hits;
  logic              adv;
  logic              fire;

  assign adv       = !out_v_r || out_tready;
  assign fire      = s1_v_r && adv;
  assign in_tready = !s1_v_r || adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_tready) begin
      s1_v_nxt = in_tvalid;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = s1_v_r;
    end
  end

  // window after the shift, newest byte first
  always_comb begin
    win[0] = s1_byte_r;
    for (int i = 1; i < tcc_pkg::WinDepth; i++) begin
      win[i] = hist_r[i-1];
    end
  end

  always_comb begin
    len_nxt = s1_start_r ? '0 : len_r;
    if (s1_count_r && (len_nxt < tcc_pkg::LEN_MAX)) begin
      len_nxt = len_nxt + tcc_pkg::len_t'(1);
    end
  end

  tcc_match u_match (
    .win  (win),
    .len  (len_nxt),
    .hits (hits)
  );

  assign flags_nxt = (s1_start_r ? '0 : flags_r) | hits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      hist_r  <= '0;
      flags_r <= '0;
      len_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (fire) begin
        hist_r  <= win;
        flags_r <= flags_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser[0];
      s1_count_r <= in_tuser[1];
    end
    if (fire) begin
      out_data_r <= {1'b0, flags_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/tcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks for the text content classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // only seven flag bits exist
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7] == 1'b0))
    else $error("padding bit set");

  // a free output never holds back the input
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tready || !out_tvalid) |-> in_tready)
    else $error("input stalled with output free");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind text_content_classifier_top tcc_checker u_tcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/tb_text_content_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_content_classifier_top
// Self-checking bench for the byte stream content classifier. A shadow copy
// of the nine-byte window, the sticky flags and the content length predicts
// the flags for every byte taken. Each returned result is compared with the
// oldest prediction. Directed bytes come first, then a long random stream
// built mostly from dates, times, temperatures, coordinates, isbn markers and
// plain text with random digits and the odd corrupted byte. Both sides idle
// in random bursts, except in the final stretch.
// ----------------------------------------------------------------------------
module tb_text_content_classifier_top;

  localparam int unsigned MAX_SHOWN   = 20;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 8;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] byte_in
  logic [1:0] in_tuser;   // [0] start_content, [1] count_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [6:0] content_flags, [7] zero

  // shadow state of the block
  logic [7:0]        hist [1:9];   // hist[1] newest byte
  tcc_pkg::flags_t   sticky_flags;
  tcc_pkg::len_t     content_len;
  tcc_pkg::flags_t   expected_flags [$];

  int unsigned       err_count;
  int unsigned       bytes_sent;
  int unsigned       results_checked;
  tcc_pkg::flags_t   flags_seen;
  bit                idle_bursts;

  text_content_classifier_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #10_000_000;
    $display("text_content_classifier_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit digit(input logic [7:0] v);
    return (v >= 8'h30) && (v <= 8'h39);
  endfunction

  function automatic tcc_pkg::flags_t match_window();
    logic [31:0]     c4;
    logic [31:0]     c8;
    tcc_pkg::flags_t f;
    c4 = {hist[4], hist[3], hist[2], hist[1]};
    c8 = {hist[8], hist[7], hist[6], hist[5]};
    f  = '0;
    // date: either four digits newest, or a four-digit year further back
    if ((c4 & tcc_pkg::M_DATE4) == tcc_pkg::P_DATE4) begin
      if (digit(hist[1]) && digit(hist[2]) && digit(hist[3]) && digit(hist[4]) &&
          (((c8 & tcc_pkg::M_DATE_A) == tcc_pkg::P_DATE_A && digit(hist[9])) ||
           (c8 & tcc_pkg::M_DATE_B) == tcc_pkg::P_DATE_B))
        f[tcc_pkg::FLAG_DATE] = 1'b1;
    end else if (((c8 & tcc_pkg::M_DATE_C) == tcc_pkg::P_DATE_C ||
                  (c8 & tcc_pkg::M_DATE_D) == tcc_pkg::P_DATE_D) &&
                 digit(hist[9])) begin
      if (digit(hist[7]) && digit(hist[8]) &&
          (c4 & tcc_pkg::M_DATE_E) == tcc_pkg::P_DATE_E)
        f[tcc_pkg::FLAG_DATE] = 1'b1;
    end
    if ((c4 & tcc_pkg::M_TIME4) == tcc_pkg::P_TIME4 && digit(hist[5]) &&
        (!digit(hist[6]) ||
         ((c8 & tcc_pkg::M_TIME8) == tcc_pkg::P_TIME8 && !digit(hist[9]))))
      f[tcc_pkg::FLAG_TIME] = 1'b1;
    if (content_len >= tcc_pkg::LEN_MAX && ((c8 | c4) & tcc_pkg::M_ASCII) == 32'h0)
      f[tcc_pkg::FLAG_TEXT] = 1'b1;
    if ((c8 & tcc_pkg::M_COORD8) == tcc_pkg::P_COORD8 &&
        (c4 & tcc_pkg::M_COORD4) == tcc_pkg::P_COORD4 &&
        digit(hist[2]) && digit(hist[3]) && digit(hist[6]) && digit(hist[7]))
      f[tcc_pkg::FLAG_COORD] = 1'b1;
    if ((c4 & tcc_pkg::M_TEMP4) == tcc_pkg::P_TEMP4 && hist[1] != tcc_pkg::CHR_G &&
        (digit(hist[4]) || (hist[4] == tcc_pkg::CHR_SPACE && digit(hist[5]))))
      f[tcc_pkg::FLAG_TEMP] = 1'b1;
    if (digit(hist[1]))
      f[tcc_pkg::FLAG_NUMBER] = 1'b1;
    if (c4 == tcc_pkg::P_ISBN && hist[5] == tcc_pkg::CHR_SPACE)
      f[tcc_pkg::FLAG_ISBN] = 1'b1;
    return f;
  endfunction

  function automatic tcc_pkg::flags_t classify_byte(input logic [7:0] b, input logic start,
                                                    input logic cnt);
    for (int i = 9; i > 1; i--)
      hist[i] = hist[i-1];
    hist[1] = b;
    if (start) begin
      sticky_flags = '0;
      content_len  = '0;
    end
    if (cnt && content_len < tcc_pkg::LEN_MAX)
      content_len = content_len + tcc_pkg::len_t'(1);
    sticky_flags = sticky_flags | match_window();
    return sticky_flags;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_SHOWN)
      $display("[%0t] mismatch, %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    tcc_pkg::flags_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_flags.size() == 0) begin
          report_mismatch("result with no request pending", out_tdata, 0);
        end else begin
          want = expected_flags.pop_front();
          results_checked++;
          flags_seen |= out_tdata[6:0];
          if (out_tdata[6:0] !== want)
            report_mismatch("content_flags", out_tdata[6:0], want);
          if (out_tdata[7] !== 1'b0)
            report_mismatch("tdata pad bit", out_tdata[7], 0);
        end
      end
      if (in_tvalid && in_tready)
        expected_flags.push_back(classify_byte(in_tdata, in_tuser[0], in_tuser[1]));
    end
  end

  // result side back-pressure
  initial begin : ready_gen
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_bursts && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic start, input logic cnt);
    if (idle_bursts && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= {cnt, start};
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    while (expected_flags.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // d digit, s date separator, u temperature unit, ~ degree sign (two bytes),
  // a printable ascii, r any byte; everything else goes out as written
  task automatic send_pattern(input string tmpl, input bit fresh, input bit noisy);
    logic [7:0] c;
    logic       st;
    logic       cn;
    int         bad_pos;
    bad_pos = (noisy && $urandom_range(0, 7) == 0) ?
              int'($urandom_range(0, tmpl.len() - 1)) : -1;
    for (int i = 0; i < tmpl.len(); i++) begin
      st = (fresh && i == 0) || (noisy && $urandom_range(0, 63) == 0);
      cn = noisy && ($urandom_range(0, 9) != 0);
      case (tmpl[i])
        "d": c = 8'h30 + 8'($urandom_range(0, 9));
        "s": c = $urandom_range(0, 1) ? "-" : "/";
        "a": c = 8'($urandom_range(8'h20, 8'h7E));
        "r": c = 8'($urandom_range(0, 255));
        "u": begin
          case ($urandom_range(0, 3))
            0:       c = "C";
            1:       c = "F";
            2:       c = "B";
            default: c = tcc_pkg::CHR_G;
          endcase
        end
        "~": begin
          send_byte(8'hC2, st, cn);
          st = 1'b0;
          c  = 8'hB0;
        end
        default: c = tmpl[i];
      endcase
      if (i == bad_pos)
        c = 8'($urandom_range(0, 255));
      send_byte(c, st, cn);
    end
  endtask

  function automatic string pick_template(input int unsigned k);
    case (k)
      0:       return "ddddsddsdd";
      1:       return "ddsddsdddd";
      2:       return "dsdsdddd";
      3:       return "dd:dd:dd";
      4:       return " dd:dd";
      5:       return "dd~u";
      6:       return "d ~u";
      7:       return "dd~dd'";
      8:       return " ISBN";
      9:       return "aaaaaaaaaa";
      10:      return "d";
      11:      return "ad:dd:dd";
      12:      return "rrrr";
      default: return "aarrd";
    endcase
  endfunction

  // ------------------------------------------------------------------- tests

  task automatic test_field_extremes();
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(8'h2F, 1'b0, 1'b1);
    send_byte(8'h30, 1'b0, 1'b0);
    send_byte(8'h39, 1'b0, 1'b1);
    send_byte(8'h3A, 1'b1, 1'b1);
  endtask

  // start on the first byte, count on every byte, then length runs past its ceiling
  task automatic test_length_saturation();
    string line;
    line = "Text line";
    for (int i = 0; i < line.len(); i++)
      send_byte(line[i], i == 0, 1'b1);
  endtask

  // uncounted bytes still go through every pattern test
  task automatic test_coordinates();
    send_pattern("dd~dd'", 1'b1, 1'b0);
  endtask

  task automatic test_pause_until_drained();
    go_quiet();
    wait_for_drain();
  endtask

  task automatic test_random_stream(input int unsigned n_bytes, input bit with_idle);
    int unsigned stop_at;
    stop_at     = bytes_sent + n_bytes;
    idle_bursts = with_idle;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0)
        idle_bursts = with_idle && ($urandom_range(0, 2) != 0);
      send_pattern(pick_template($urandom_range(0, 13)), $urandom_range(0, 2) == 0, 1'b1);
    end
  endtask

  initial begin : main_seq
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    rst_n           = 1'b0;
    idle_bursts     = 1'b1;
    err_count       = 0;
    bytes_sent      = 0;
    results_checked = 0;
    flags_seen      = '0;
    for (int i = 1; i <= 9; i++)
      hist[i] = 8'h00;
    sticky_flags = '0;
    content_len  = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_length_saturation();
    test_coordinates();
    test_pause_until_drained();
    test_random_stream(700, 1'b1);
    test_pause_until_drained();
    test_random_stream(450, 1'b1);
    test_random_stream(320, 1'b0);

    go_quiet();
    idle_bursts = 1'b0;
    wait_for_drain();
    if (expected_flags.size() != 0)
      report_mismatch("results never returned", expected_flags.size(), 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d bytes and %0d checked results: field extremes, length ceiling,",
             bytes_sent, results_checked);
    $display("coordinates, patterned random stream with idle bursts; flag bits seen %b",
             flags_seen);
    if (err_count == 0) begin
      $display("text_content_classifier_top verification clean");
    end else begin
      $display("text_content_classifier_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tcc_pkg.sv
rtl/tcc_match.sv
rtl/text_content_classifier_top.sv
rtl/tcc_checker.sv
bench/tb_text_content_classifier_top.sv
